### hw/rtl/sukt_pkg.sv
// Shared types, constants and helpers for the sorted unique key table.
package sukt_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_BITS  = 32;
    localparam int IN_KEY_W  = 32;
    localparam int SLOT_W    = 7;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SPAN_W    = (KEY_BITS > CNT_W) ? KEY_BITS : CNT_W;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_DUP  = 2'd2,
        STAT_FULL = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic                       op;
        logic signed [IN_KEY_W-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic              contiguous;
    } rsp_item_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic                valid;
        logic                lt;
        logic [KEY_BITS-1:0] key;
    } cell_link_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                cmp_en;
        logic [KEY_BITS-1:0] cmp_key;
        logic                ins_en;
        logic [KEY_BITS-1:0] ins_key;
    } cell_cmd_t;

    // Sign-extend, keep KEY_BITS bits and flip the sign bit, so that unsigned
    // order of the result is signed order of the key.
    function automatic logic [KEY_BITS-1:0] bias_key(input logic signed [IN_KEY_W-1:0] k);
        logic [63:0]         wide;
        logic [KEY_BITS-1:0] kb;
        wide = 64'(k);
        kb = wide[KEY_BITS-1:0];
        kb[KEY_BITS-1] = ~kb[KEY_BITS-1];
        return kb;
    endfunction

endpackage

### hw/rtl/sorted_unique_key_table_core.sv
// Top level of the sorted unique key table: cell chain, controller and result register.
//
// The table keeps up to 64 signed keys in ascending order with no duplicates,
// one key per cell in a chain of compare-and-shift cells. Each item passes
// through the idle and update states: on the transfer edge every cell
// compares its key with the incoming key, and when the update commits the
// controller decides the outcome from those compare bits, the cells shift
// right by one from the insertion point on an insert, and the result is
// loaded into the output register. The next item is taken once that update
// is done, so no new item is accepted while one is in flight; a stalled result
// that still occupies the output register holds back the next item's update.
// The table starts empty after reset and needs no clearing pass.
module sorted_unique_key_table_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sukt_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sukt_pkg::rsp_item_t rsp_item
);
    import sukt_pkg::*;

    state_t              state_reg, state_next;
    logic                req_fire;
    logic                out_free;
    logic                commit;

    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [KEY_BITS-1:0] last_reg, last_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg;

    cell_cmd_t           cmd;
    cell_link_t          link [0:DEPTH];
    logic [DEPTH-1:0]    eq_vec;
    logic [DEPTH-1:0]    lt_vec;
    logic [DEPTH-1:0]    valid_vec;

    logic [CNT_W-1:0]    pos;
    logic                present;
    logic                full;
    logic                ins;
    logic                at_front;
    logic                at_end;
    logic [KEY_BITS-1:0] first_next;
    logic [KEY_BITS-1:0] span;
    logic                contig;
    status_t             status;

    assign req_fire = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Controller: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller: outputs.
    always_comb
    begin
        req_stall = 1'b1;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_stall = 1'b0;
            ST_UPD:  commit    = out_free;
            default: req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Cell chain. The entry link acts as an always-valid key below everything.
    assign link[0].valid = 1'b1;
    assign link[0].lt    = 1'b1;
    assign link[0].key   = '0;

    assign cmd.cmp_en  = req_fire;
    assign cmd.cmp_key = bias_key(req_item.key);
    assign cmd.ins_en  = commit && ins;
    assign cmd.ins_key = key_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            sukt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (link[gi]),
                .right (link[gi+1]),
                .eq    (eq_vec[gi])
            );
            assign lt_vec[gi]    = link[gi+1].lt;
            assign valid_vec[gi] = link[gi+1].valid;
        end
    endgenerate

    // The lower bound sits where the prefix of smaller keys ends.
    always_comb
    begin
        logic prev_lt;
        logic cur_lt;
        pos = '0;
        for (int i = 0; i <= DEPTH; i++)
        begin
            prev_lt = (i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1];
            cur_lt  = (i == DEPTH) ? 1'b0 : lt_vec[(i == DEPTH) ? 0 : i];
            if (prev_lt && !cur_lt)
                pos = pos | CNT_W'(i);
        end
    end

    assign present  = |eq_vec;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign ins      = (op_reg == OP_INSERT) && !present && !full;
    assign at_front = !lt_vec[0];
    assign at_end   = !(|(valid_vec & ~lt_vec));

    always_comb
    begin
        priority if (op_reg == OP_LOOKUP)
            status = present ? STAT_OK : STAT_MISS;
        else if (present)
            status = STAT_DUP;
        else if (full)
            status = STAT_FULL;
        else
            status = STAT_OK;
    end

    assign count_next = ins ? count_reg + CNT_W'(1) : count_reg;
    assign first_next = (ins && at_front) ? key_reg : link[1].key;
    assign last_next  = (ins && at_end) ? key_reg : last_reg;
    assign span       = last_next - first_next;
    assign contig     = (count_next != '0)
                        && (SPAN_W'(span) == SPAN_W'(count_next - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
                count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= req_item.op;
            key_reg <= bias_key(req_item.key);
        end
        if (commit)
        begin
            last_reg           <= last_next;
            rsp_reg.status     <= status;
            rsp_reg.slot       <= SLOT_W'(pos);
            rsp_reg.count      <= SLOT_W'(count_next);
            rsp_reg.contiguous <= contig;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

### hw/rtl/sukt_cell.sv
// One table cell: holds a key, compares it with the search key and shifts right on insert.
module sukt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sukt_pkg::cell_cmd_t cmd,
    input  sukt_pkg::cell_link_t left,
    output sukt_pkg::cell_link_t right,
    output logic                eq
);
    import sukt_pkg::*;

    logic                valid_reg, valid_next;
    logic                lt_reg, lt_next;
    logic                eq_reg, eq_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                take;

    // A cell at or after the insertion point takes over its left neighbor's
    // key; the cell right at the insertion point takes the new key instead.
    assign take = cmd.ins_en && left.valid && !lt_reg;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.cmp_en)
        begin
            lt_next = valid_reg && (key_reg < cmd.cmp_key);
            eq_next = valid_reg && (key_reg == cmd.cmp_key);
        end
        if (take)
        begin
            valid_next = 1'b1;
            key_next   = left.lt ? cmd.ins_key : left.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign right.valid = valid_reg;
    assign right.lt    = lt_reg;
    assign right.key   = key_reg;
    assign eq          = eq_reg;

endmodule
